@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the field parser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PFP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define PFP_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// An implication checked in the following cycle.
`define PFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pfp_pkg.sv @@
// ---------------------------------------------------------------------------
// Field parser package
// Constants, codes and types shared by the field parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pfp_pkg;

    localparam int MAX_FIELDS  = 16;
    localparam int OFFSET_BITS = 16;
    localparam int NUM_IDS     = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CFG_IDX_W   = 3;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    localparam logic [1:0] PH_TAG    = 2'd0;
    localparam logic [1:0] PH_VARINT = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    localparam logic [2:0] WT_LEN = 3'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_TAG  = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_REQUIRED = 3'd5;

    localparam logic RES_FIELD  = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_TYPES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_3  = 3'd5;

    typedef struct packed {
        logic       present;
        logic       eom;
        logic       cont;
        logic [6:0] low7;
        logic [4:0] tag_id;
        logic [2:0] tag_wtype;
    } pfp_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  id;
        logic [31:0] value;
        logic [15:0] offset;
        logic [2:0]  status;
        logic        last;
    } pfp_result_t;

    typedef struct packed {
        logic [4:0]               field_count;
        logic [63:0]              field_types;
        logic [NUM_IDS-1:0][15:0] expected;
    } pfp_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfp_front.sv @@
// ---------------------------------------------------------------------------
// Field parser front end
// Accepts message bytes, splits them into tag and varint views and
// registers each item for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module pfp_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_data_byte,
    input  wire logic              s_byte_present,
    input  wire logic              s_end_of_message,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output pfp_pkg::pfp_item_t     push_item
);
    import pfp_pkg::*;

    logic      valid_reg, valid_next;
    pfp_item_t item_reg, item_next;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next          = 1'b1;
            item_next.present   = s_byte_present;
            item_next.eom       = s_end_of_message;
            item_next.cont      = s_data_byte[7];
            item_next.low7      = s_data_byte[6:0];
            item_next.tag_id    = s_data_byte[7:3];
            item_next.tag_wtype = s_data_byte[2:0];
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfp_queue.sv @@
// ---------------------------------------------------------------------------
// Field parser item queue
// Short first-in first-out queue of classified items between the front
// end and the parse engine.
// ---------------------------------------------------------------------------
`default_nettype none

module pfp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire pfp_pkg::pfp_item_t push_item,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output pfp_pkg::pfp_item_t     pop_item
);
    import pfp_pkg::*;

    pfp_item_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic                   do_push, do_pop;

    assign push_ready = count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/pfp_back.sv @@
// ---------------------------------------------------------------------------
// Field parser engine
// Runs the tag, varint and payload skip phases on queued items and holds
// up to two results for the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfp_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pfp_pkg::pfp_cfg_t  cfg,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire pfp_pkg::pfp_item_t pop_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_result_kind,
    output logic [3:0]              m_field_id,
    output logic [31:0]             m_field_value,
    output logic [15:0]             m_payload_offset,
    output logic [2:0]              m_status,
    output logic                    m_last_result
);
    import pfp_pkg::*;

    logic                   load_pending_reg, load_pending_next;
    logic [1:0]             phase_reg, phase_next;
    logic [3:0]             field_reg, field_next;
    logic [2:0]             wtype_reg, wtype_next;
    logic [31:0]            accum_reg, accum_next;
    logic [5:0]             shift_reg, shift_next;
    logic [31:0]            skip_reg, skip_next;
    logic [NUM_IDS-1:0]     found_reg, found_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [2:0]             err_reg, err_next;
    logic [31:0]            seen_reg [NUM_IDS];

    logic [1:0]             out_count_reg, out_count_next;
    pfp_result_t            ob0_reg, ob0_next, ob1_reg, ob1_next;

    logic                   take_item, out_pop;
    logic [1:0]             phase_cur;
    logic [NUM_IDS-1:0]     found_cur;
    logic [OFFSET_BITS-1:0] offset_cur, pay_off;
    logic [2:0]             err_cur;
    logic [4:0]             eff_count;
    logic                   tag_bad;
    logic [31:0]            shifted, acc_new, seen_cur, skip_dec;
    logic                   seen_we;
    logic [NUM_IDS-1:0]     req_mask;
    logic                   rep_valid;
    pfp_result_t            rep, stat;

    assign out_pop   = m_valid && m_ready;
    assign take_item = pop_valid &&
                       ((out_count_reg == 2'd0) || (out_count_reg == 2'd1 && out_pop));
    assign pop_ready = take_item;

    assign m_valid          = out_count_reg != 2'd0;
    assign m_result_kind    = ob0_reg.kind;
    assign m_field_id       = ob0_reg.id;
    assign m_field_value    = ob0_reg.value;
    assign m_payload_offset = ob0_reg.offset;
    assign m_status         = ob0_reg.status;
    assign m_last_result    = ob0_reg.last;

    assign eff_count = (cfg.field_count > 5'(MAX_FIELDS)) ? 5'(MAX_FIELDS) : cfg.field_count;

    always_comb begin
        phase_cur  = load_pending_reg ? PH_TAG : phase_reg;
        found_cur  = load_pending_reg ? '0 : found_reg;
        offset_cur = load_pending_reg ? '0 : offset_reg;
        err_cur    = load_pending_reg ? ST_OK : err_reg;

        load_pending_next = load_pending_reg;
        phase_next  = phase_reg;
        field_next  = field_reg;
        wtype_next  = wtype_reg;
        accum_next  = accum_reg;
        shift_next  = shift_reg;
        skip_next   = skip_reg;
        found_next  = found_reg;
        offset_next = offset_reg;
        err_next    = err_reg;
        seen_we     = 1'b0;
        rep_valid   = 1'b0;
        pay_off     = '0;

        tag_bad  = (pop_item.tag_id >= eff_count) ||
                   (pop_item.tag_wtype != cfg.field_types[{pop_item.tag_id[3:0], 2'b00} +: 3]);
        shifted  = {25'b0, pop_item.low7} << shift_reg;
        acc_new  = (shift_reg < 6'd32) ? (accum_reg | shifted) : accum_reg;
        seen_cur = seen_reg[field_reg];
        skip_dec = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

        for (int i = 0; i < NUM_IDS; i++) begin
            req_mask[i] = cfg.field_types[4*i+3] && (5'(i) < eff_count);
        end

        if (take_item) begin
            phase_next        = phase_cur;
            found_next        = found_cur;
            offset_next       = offset_cur;
            err_next          = err_cur;
            load_pending_next = 1'b0;

            if (pop_item.present && err_cur == ST_OK) begin
                case (phase_cur)
                    PH_TAG: begin
                        if (tag_bad) begin
                            err_next = ST_BAD_TAG;
                        end else begin
                            found_next[pop_item.tag_id[3:0]] = 1'b1;
                            field_next = pop_item.tag_id[3:0];
                            wtype_next = pop_item.tag_wtype;
                            accum_next = '0;
                            shift_next = '0;
                            phase_next = PH_VARINT;
                        end
                    end
                    PH_VARINT: begin
                        accum_next = acc_new;
                        if (shift_reg < 6'd32) begin
                            shift_next = shift_reg + 6'd7;
                        end
                        if (!pop_item.cont) begin
                            if (seen_cur != '0 && seen_cur != acc_new) begin
                                err_next = ST_MISMATCH;
                            end else begin
                                seen_we    = 1'b1;
                                rep_valid  = 1'b1;
                                phase_next = PH_TAG;
                                if (wtype_reg == WT_LEN) begin
                                    pay_off   = (offset_cur != OFFSET_MAX) ?
                                                offset_cur + 1'b1 : OFFSET_MAX;
                                    skip_next = acc_new;
                                    if (acc_new != '0) begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        skip_next = skip_dec;
                        if (skip_dec == '0) begin
                            phase_next = PH_TAG;
                        end
                    end
                endcase
            end

            if (pop_item.present && offset_cur != OFFSET_MAX) begin
                offset_next = offset_cur + 1'b1;
            end

            if (pop_item.eom) begin
                load_pending_next = 1'b1;
                if (err_next == ST_OK) begin
                    if (phase_next == PH_VARINT) begin
                        err_next = ST_TRUNC;
                    end else if (phase_next == PH_SKIP && skip_next != '0) begin
                        err_next = ST_OVERRUN;
                    end else if ((req_mask & ~found_next) != '0) begin
                        err_next = ST_REQUIRED;
                    end
                end
            end
        end

        rep.kind   = RES_FIELD;
        rep.id     = field_reg;
        rep.value  = acc_new;
        rep.offset = 16'(pay_off);
        rep.status = ST_OK;
        rep.last   = 1'b0;

        stat.kind   = RES_STATUS;
        stat.id     = '0;
        stat.value  = '0;
        stat.offset = '0;
        stat.status = err_next;
        stat.last   = 1'b1;

        out_count_next = out_count_reg;
        ob0_next       = ob0_reg;
        ob1_next       = ob1_reg;
        if (take_item) begin
            out_count_next = 2'({1'b0, rep_valid} + {1'b0, pop_item.eom});
            ob0_next       = rep_valid ? rep : stat;
            ob1_next       = stat;
        end else if (out_pop) begin
            out_count_next = out_count_reg - 1'b1;
            ob0_next       = ob1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pending_reg <= 1'b1;
            phase_reg        <= PH_TAG;
            field_reg        <= '0;
            wtype_reg        <= '0;
            accum_reg        <= '0;
            shift_reg        <= '0;
            skip_reg         <= '0;
            found_reg        <= '0;
            offset_reg       <= '0;
            err_reg          <= ST_OK;
            out_count_reg    <= '0;
        end else begin
            load_pending_reg <= load_pending_next;
            phase_reg        <= phase_next;
            field_reg        <= field_next;
            wtype_reg        <= wtype_next;
            accum_reg        <= accum_next;
            shift_reg        <= shift_next;
            skip_reg         <= skip_next;
            found_reg        <= found_next;
            offset_reg       <= offset_next;
            err_reg          <= err_next;
            out_count_reg    <= out_count_next;
        end
        ob0_reg <= ob0_next;
        ob1_reg <= ob1_next;
    end

    always_ff @(posedge aclk) begin
        if (take_item && load_pending_reg) begin
            for (int i = 0; i < NUM_IDS; i++) begin
                seen_reg[i] <= {16'b0, cfg.expected[i]};
            end
        end else if (seen_we) begin
            seen_reg[field_reg] <= acc_new;
        end
    end

    `PFP_ASSERT_NEXT(a_err_sticky, aclk, aresetn,
                     (err_reg != ST_OK && !load_pending_reg), (err_reg == $past(err_reg)),
                     "error code changed before the message ended")
    `PFP_ASSERT_IMPL(a_skip_nonzero, aclk, aresetn,
                     (phase_reg == PH_SKIP && !load_pending_reg), (skip_reg != '0),
                     "skip phase with nothing left to skip")
    `PFP_ASSERT(a_shift_limit, aclk, aresetn, (shift_reg <= 6'd35),
                "varint shift ran past its limit")
    `PFP_ASSERT_IMPL(a_second_is_status, aclk, aresetn, (out_count_reg == 2'd2),
                     (ob1_reg.kind == RES_STATUS && ob0_reg.kind == RES_FIELD),
                     "two held results are not a report then a status")

endmodule

`default_nettype wire

@@ hw/rtl/protobuf_field_parser_unit.sv @@
// ---------------------------------------------------------------------------
// Protobuf field parser unit
// Byte-wise parser of single-byte-tag Protobuf messages with per-field
// type, required and expected value checks.
// ---------------------------------------------------------------------------
// Usage:
// The s_ channel takes one message byte per item, with byte_present and
// end_of_message flags; the m_ channel gives field reports and one final
// status item per message. Both use valid and ready.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while
// the unit is idle; registers take effect at the next message.
// Throughput is one input item per cycle while m_ready is high and no item
// gives two results. An item passes an input register, a four-entry queue
// and the engine's result buffer before its results are visible. An item
// that completes a field and ends the message gives two results, which leave
// in turn; the engine takes the next item once its result buffer is drained.
// When the receiver stalls, results wait in the engine's two-entry buffer,
// then the queue and the input register fill and s_ready falls.
// Reset clears the queue, the buffer and the parse state and loads the
// register reset values; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module protobuf_field_parser_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire logic                          s_byte_present,
    input  wire logic                          s_end_of_message,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic [3:0]                         m_field_id,
    output logic [31:0]                        m_field_value,
    output logic [15:0]                        m_payload_offset,
    output logic [2:0]                         m_status,
    output logic                               m_last_result
);
    import pfp_pkg::*;

    logic [4:0]       field_count_reg;
    logic [63:0]      field_types_reg;
    logic [3:0][63:0] expected_reg;
    pfp_cfg_t         cfg;

    logic      push_valid, push_ready, pop_valid, pop_ready;
    pfp_item_t push_item, pop_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_count_reg <= 5'd16;
            field_types_reg <= '0;
            expected_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FIELD_COUNT: field_count_reg <= cfg_data[4:0];
                CFG_FIELD_TYPES: field_types_reg <= cfg_data;
                CFG_EXPECTED_0:  expected_reg[0] <= cfg_data;
                CFG_EXPECTED_1:  expected_reg[1] <= cfg_data;
                CFG_EXPECTED_2:  expected_reg[2] <= cfg_data;
                CFG_EXPECTED_3:  expected_reg[3] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg.field_count = field_count_reg;
    assign cfg.field_types = field_types_reg;
    assign cfg.expected    = expected_reg;

    pfp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_item        (push_item)
    );

    pfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pfp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_field_id       (m_field_id),
        .m_field_value    (m_field_value),
        .m_payload_offset (m_payload_offset),
        .m_status         (m_status),
        .m_last_result    (m_last_result)
    );

endmodule

`default_nettype wire
